### hw/rtl/wireless_intrusion_rate_detector_top_defines.svh
// assertion macros for the wireless intrusion rate detector
`ifndef WIRELESS_INTRUSION_RATE_DETECTOR_TOP_DEFINES_SVH
`define WIRELESS_INTRUSION_RATE_DETECTOR_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define WIRD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("wird assertion failed");
`define WIRD_ASSERT_ANY(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("wird assertion failed");
`else
`define WIRD_ASSERT(lbl, prop)
`define WIRD_ASSERT_ANY(lbl, prop)
`endif
`endif

### hw/rtl/wird_pkg.sv
// types and constants of the wireless intrusion rate detector
package wird_pkg;
    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_UPD, ST_EMIT} t_state;

    localparam logic [2:0] K_ASSOC = 3'd0;
    localparam logic [2:0] K_PROBE = 3'd1;
    localparam logic [2:0] K_AUTH = 3'd2;
    localparam logic [2:0] K_DEAUTH = 3'd3;
    localparam logic [2:0] K_TWIN = 3'd4;
    localparam logic [2:0] K_BFLOOD = 3'd5;
    localparam logic [2:0] K_EAPOL = 3'd6;
    localparam logic [2:0] K_NONE = 3'd7;

    localparam logic [2:0] EV_DEAUTH = 3'd0;
    localparam logic [2:0] EV_AUTH = 3'd1;
    localparam logic [2:0] EV_PROBE = 3'd2;
    localparam logic [2:0] EV_ASSOC = 3'd3;
    localparam logic [2:0] EV_COAP = 3'd4;
    localparam logic [2:0] EV_TWIN = 3'd5;
    localparam logic [2:0] EV_BFLOOD = 3'd6;
    localparam logic [2:0] EV_HARVEST = 3'd7;

    localparam logic [1:0] SEV_INFO = 2'd0;
    localparam logic [1:0] SEV_WARN = 2'd1;
    localparam logic [1:0] SEV_CRIT = 2'd2;

    localparam logic [2:0] REG_TARGET = 3'd0;
    localparam logic [2:0] REG_DEAUTH = 3'd1;
    localparam logic [2:0] REG_PROBE = 3'd2;
    localparam logic [2:0] REG_ASSOC = 3'd3;
    localparam logic [2:0] REG_FLOOD = 3'd4;
    localparam logic [2:0] REG_HSMIN = 3'd5;

    localparam logic [31:0] LONG_WIN = 32'd10000;
    localparam logic [31:0] SHORT_WIN = 32'd5000;
    localparam logic [31:0] BURST_WIN = 32'd30000;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;
endpackage

### hw/rtl/wird_if.sv
// frame and event channel interfaces
interface wird_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic [47:0] src_mac;
    logic [2:0]  eapol_msg;
    logic [31:0] now_ms;
    modport source (output valid, req_type, src_mac, eapol_msg, now_ms, input ready);
    modport sink (input valid, req_type, src_mac, eapol_msg, now_ms, output ready);
endinterface

interface wird_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_kind;
    logic [1:0]  severity;
    logic [47:0] event_mac;
    logic [2:0]  event_msg_num;
    logic [1:0]  max_severity;
    modport source (output valid, event_kind, severity, event_mac, event_msg_num,
                    max_severity, input ready);
    modport sink (input valid, event_kind, severity, event_mac, event_msg_num,
                  max_severity, output ready);
endinterface

### hw/rtl/wird_ram.sv
// single write port ram with registered read
module wird_ram #(
    parameter int W  = 48,
    parameter int AW = 4
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);
    logic [W-1:0] r_mem [2**AW];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### hw/rtl/wireless_intrusion_rate_detector_top.sv
// wireless intrusion rate detector top level
// a frame with no table search goes to idle, or to emit with an event (beacon flood, harvest)
// a table search reads the used entries one per cycle, then updates the entry, then emits
// an event if one is raised; the counter, twin and auth tables are searched alike
// one frame at a time; an event waits in emit while the output beat is held by backpressure
// synchronous active-low reset clears control, counts and configuration; no ram clear
`include "wireless_intrusion_rate_detector_top_defines.svh"
module wireless_intrusion_rate_detector_top
    import wird_pkg::*;
#(
    parameter int CTR_ENTRIES  = 16,
    parameter int AUTH_ENTRIES = 32,
    parameter int TWIN_ENTRIES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wird_in_if.sink     i_in,
    wird_out_if.source  o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    localparam int MAXE = (CTR_ENTRIES > AUTH_ENTRIES)
        ? ((CTR_ENTRIES > TWIN_ENTRIES) ? CTR_ENTRIES : TWIN_ENTRIES)
        : ((AUTH_ENTRIES > TWIN_ENTRIES) ? AUTH_ENTRIES : TWIN_ENTRIES);
    localparam int IX_W = $clog2(MAXE + 1);
    localparam int CI_W = (CTR_ENTRIES > 1) ? $clog2(CTR_ENTRIES) : 1;
    localparam int CU_W = $clog2(CTR_ENTRIES + 1);
    localparam int AU_W = $clog2(AUTH_ENTRIES + 1);
    localparam int TU_W = $clog2(TWIN_ENTRIES + 1);
    localparam int SA_W = $clog2(AUTH_ENTRIES + TWIN_ENTRIES);

    t_state r_state, n_state;

    logic [47:0] r_target;
    logic [15:0] r_thr_deauth, r_thr_probe, r_thr_assoc;
    logic [5:0]  r_flood;
    logic [7:0]  r_hsmin;

    logic [2:0]  r_kind, n_kind;
    logic [47:0] r_mac, n_mac;
    logic [31:0] r_now, n_now;
    logic [IX_W-1:0] r_idx, n_idx, r_rd_idx, n_rd_idx, r_pick, n_pick, r_min_idx, n_min_idx;
    logic        r_rd_vld, n_rd_vld, r_found, n_found;
    logic [31:0] r_min_start, n_min_start;
    logic [15:0] r_cnt, n_cnt;
    logic [31:0] r_start, n_start;
    logic [2:0]  r_ev_kind, n_ev_kind;
    logic [1:0]  r_ev_sev, n_ev_sev;
    logic [2:0]  r_ev_msg, n_ev_msg;

    logic [CU_W-1:0] r_shared_used, n_shared_used, r_probe_used, n_probe_used;
    logic [AU_W-1:0] r_auth_used, n_auth_used;
    logic            r_auth_fired, n_auth_fired;
    logic [31:0]     r_auth_ws, n_auth_ws, r_burst_start, n_burst_start;
    logic [15:0]     r_burst_count, n_burst_count;
    logic [TU_W-1:0] r_twin_used, n_twin_used;
    logic [1:0]      r_peak, n_peak;

    logic        r_ov, n_ov;
    logic [2:0]  r_o_kind, n_o_kind, r_o_msg, n_o_msg;
    logic [1:0]  r_o_sev, n_o_sev, r_o_max, n_o_max;
    logic [47:0] r_o_mac, n_o_mac;

    logic            ctr_we, set_we;
    logic [CI_W:0]   ctr_waddr, ctr_raddr;
    logic [95:0]     ctr_wdata, ctr_rdata;
    logic [SA_W-1:0] set_waddr, set_raddr;
    logic [47:0]     set_rdata;

    logic            is_ctr, is_twin, match, ev, wexp;
    logic [IX_W-1:0] lim;
    logic [CU_W-1:0] cu;
    logic [15:0]     cnt, thr, bc;
    logic [31:0]     st, win;
    logic [AU_W-1:0] au;

    wird_ram #(.W(96), .AW(CI_W + 1)) u_ctr_ram (
        .i_clk(i_clk), .i_we(ctr_we), .i_waddr(ctr_waddr), .i_wdata(ctr_wdata),
        .i_raddr(ctr_raddr), .o_rdata(ctr_rdata)
    );

    wird_ram #(.W(48), .AW(SA_W)) u_set_ram (
        .i_clk(i_clk), .i_we(set_we), .i_waddr(set_waddr), .i_wdata(r_mac),
        .i_raddr(set_raddr), .o_rdata(set_rdata)
    );

    // configuration port
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target     <= '0;
            r_thr_deauth <= 16'd5;
            r_thr_probe  <= 16'd50;
            r_thr_assoc  <= 16'd5;
            r_flood      <= 6'd32;
            r_hsmin      <= 8'd3;
        end else if (psel && penable && pwrite) begin
            case (paddr[5:3])
                REG_TARGET: r_target     <= pwdata[47:0];
                REG_DEAUTH: r_thr_deauth <= pwdata[15:0];
                REG_PROBE:  r_thr_probe  <= pwdata[15:0];
                REG_ASSOC:  r_thr_assoc  <= pwdata[15:0];
                REG_FLOOD:  r_flood      <= pwdata[5:0];
                REG_HSMIN:  r_hsmin      <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[5:3])
            REG_TARGET: prdata = {16'd0, r_target};
            REG_DEAUTH: prdata = {48'd0, r_thr_deauth};
            REG_PROBE:  prdata = {48'd0, r_thr_probe};
            REG_ASSOC:  prdata = {48'd0, r_thr_assoc};
            REG_FLOOD:  prdata = {58'd0, r_flood};
            REG_HSMIN:  prdata = {56'd0, r_hsmin};
            default:    prdata = '0;
        endcase
    end

    // search control
    assign is_ctr  = (r_kind == K_ASSOC) || (r_kind == K_PROBE) || (r_kind == K_DEAUTH);
    assign is_twin = (r_kind == K_TWIN);

    always_comb begin
        case (r_kind)
            K_PROBE:  lim = IX_W'(r_probe_used);
            K_AUTH:   lim = IX_W'(r_auth_used);
            K_TWIN:   lim = IX_W'(r_twin_used);
            default:  lim = IX_W'(r_shared_used);
        endcase
    end

    assign ctr_raddr = {(r_kind == K_PROBE), r_idx[CI_W-1:0]};
    assign set_raddr = is_twin ? SA_W'(AUTH_ENTRIES) + SA_W'(r_idx) : SA_W'(r_idx);
    assign match = r_rd_vld && (is_ctr ? (ctr_rdata[95:48] == r_mac) : (set_rdata == r_mac));
    assign i_in.ready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        n_kind = r_kind; n_mac = r_mac; n_now = r_now;
        n_idx = r_idx; n_rd_idx = r_rd_idx; n_rd_vld = 1'b0;
        n_pick = r_pick; n_min_idx = r_min_idx; n_found = r_found;
        n_min_start = r_min_start; n_cnt = r_cnt; n_start = r_start;
        n_ev_kind = r_ev_kind; n_ev_sev = r_ev_sev; n_ev_msg = r_ev_msg;
        n_shared_used = r_shared_used; n_probe_used = r_probe_used;
        n_auth_used = r_auth_used; n_auth_fired = r_auth_fired; n_auth_ws = r_auth_ws;
        n_burst_start = r_burst_start; n_burst_count = r_burst_count;
        n_twin_used = r_twin_used; n_peak = r_peak;
        n_ov = r_ov && !o_out.ready;
        n_o_kind = r_o_kind; n_o_sev = r_o_sev; n_o_mac = r_o_mac;
        n_o_msg = r_o_msg; n_o_max = r_o_max;
        ctr_we = 1'b0; set_we = 1'b0;
        ctr_waddr = {(r_kind == K_PROBE), r_pick[CI_W-1:0]};
        set_waddr = SA_W'(r_idx);
        cu = '0; au = '0; cnt = '0; st = '0; thr = '0; bc = '0; ev = 1'b0;
        win = SHORT_WIN; wexp = 1'b0;
        ctr_wdata = '0;

        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_kind = i_in.req_type;
                    n_mac  = i_in.src_mac;
                    n_now  = i_in.now_ms;
                    n_idx  = '0;
                    n_ev_msg = 3'd0;
                    case (i_in.req_type)
                        K_ASSOC, K_PROBE, K_DEAUTH, K_TWIN: n_state = ST_SCAN;
                        K_AUTH: begin
                            wexp = (i_in.now_ms - r_auth_ws) > LONG_WIN;
                            if (wexp) begin
                                n_auth_ws = i_in.now_ms;
                                n_auth_used = '0;
                                n_auth_fired = 1'b0;
                                n_state = ST_SCAN;
                            end else if (!r_auth_fired) begin
                                n_state = ST_SCAN;
                            end
                        end
                        K_BFLOOD: begin
                            n_ev_kind = EV_BFLOOD;
                            n_ev_sev = SEV_WARN;
                            n_state = ST_EMIT;
                        end
                        K_EAPOL: begin
                            if (r_burst_count >= {8'd0, r_hsmin} &&
                                (i_in.now_ms - r_burst_start) < BURST_WIN) begin
                                n_ev_kind = EV_HARVEST;
                                n_ev_sev = SEV_CRIT;
                                n_ev_msg = i_in.eapol_msg;
                                n_burst_count = '0;
                                n_state = ST_EMIT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN: begin
                if (match) begin
                    n_found = 1'b1;
                    n_pick = r_rd_idx;
                    n_cnt = ctr_rdata[47:32];
                    n_start = ctr_rdata[31:0];
                    n_state = ST_UPD;
                end else begin
                    // oldest entry for replacement
                    if (r_rd_vld && is_ctr &&
                        (r_rd_idx == '0 || ctr_rdata[31:0] < r_min_start)) begin
                        n_min_start = ctr_rdata[31:0];
                        n_min_idx = r_rd_idx;
                    end
                    if (r_idx < lim) begin
                        n_rd_vld = 1'b1;
                        n_rd_idx = r_idx;
                        n_idx = r_idx + 1'b1;
                    end else if (!r_rd_vld) begin
                        n_found = 1'b0;
                        n_state = ST_UPD;
                    end
                end
            end
            ST_UPD: begin
                n_found = 1'b0;
                n_state = ST_IDLE;
                if (is_ctr) begin
                    cu = (r_kind == K_PROBE) ? r_probe_used : r_shared_used;
                    cnt = r_cnt;
                    st = r_start;
                    if (!r_found) begin
                        cnt = '0;
                        st = r_now;
                        if (cu < CU_W'(CTR_ENTRIES)) begin
                            ctr_waddr = {(r_kind == K_PROBE), cu[CI_W-1:0]};
                            if (r_kind == K_PROBE) n_probe_used = cu + 1'b1;
                            else n_shared_used = cu + 1'b1;
                        end else begin
                            ctr_waddr = {(r_kind == K_PROBE), r_min_idx[CI_W-1:0]};
                        end
                    end
                    win = (r_kind == K_DEAUTH) ? LONG_WIN : SHORT_WIN;
                    if ((r_now - st) > win) begin
                        cnt = '0;
                        st = r_now;
                    end
                    if (cnt < COUNT_MAX) cnt = cnt + 16'd1;
                    ctr_we = 1'b1;
                    ctr_wdata = {r_mac, cnt, st};
                    case (r_kind)
                        K_PROBE:  thr = r_thr_probe;
                        K_DEAUTH: thr = r_thr_deauth;
                        default:  thr = r_thr_assoc;
                    endcase
                    ev = (cnt == thr);
                    n_ev_kind = (r_kind == K_PROBE) ? EV_PROBE :
                                (r_kind == K_DEAUTH) ? EV_DEAUTH : EV_ASSOC;
                    n_ev_sev = (r_kind == K_DEAUTH) ? SEV_CRIT : SEV_WARN;
                    if (r_kind == K_DEAUTH) begin
                        bc = r_burst_count;
                        if ((r_now - r_burst_start) > BURST_WIN) begin
                            n_burst_start = r_now;
                            bc = '0;
                        end
                        n_burst_count = (bc < COUNT_MAX) ? bc + 16'd1 : bc;
                    end
                end else if (is_twin) begin
                    if (!r_found) begin
                        if (r_twin_used < TU_W'(TWIN_ENTRIES)) begin
                            set_we = 1'b1;
                            set_waddr = SA_W'(AUTH_ENTRIES) + SA_W'(r_twin_used);
                            n_twin_used = r_twin_used + 1'b1;
                        end
                        ev = 1'b1;
                        if (r_mac[47:24] == r_target[47:24]) begin
                            n_ev_kind = EV_COAP;
                            n_ev_sev = SEV_INFO;
                        end else begin
                            n_ev_kind = EV_TWIN;
                            n_ev_sev = SEV_WARN;
                        end
                    end
                end else begin
                    au = r_auth_used;
                    if (!r_found && au < AU_W'(AUTH_ENTRIES)) begin
                        set_we = 1'b1;
                        set_waddr = SA_W'(au);
                        au = au + 1'b1;
                    end
                    n_auth_used = au;
                    if (8'(au) >= 8'(r_flood)) begin
                        n_auth_fired = 1'b1;
                        ev = 1'b1;
                        n_ev_kind = EV_AUTH;
                        n_ev_sev = SEV_WARN;
                    end
                end
                if (ev) n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (!r_ov || o_out.ready) begin
                    n_peak = (r_ev_sev > r_peak) ? r_ev_sev : r_peak;
                    n_ov = 1'b1;
                    n_o_kind = r_ev_kind;
                    n_o_sev = r_ev_sev;
                    n_o_mac = r_mac;
                    n_o_msg = r_ev_msg;
                    n_o_max = n_peak;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld      <= 1'b0;
            r_found       <= 1'b0;
            r_shared_used <= '0;
            r_probe_used  <= '0;
            r_auth_used   <= '0;
            r_auth_fired  <= 1'b0;
            r_auth_ws     <= '0;
            r_burst_start <= '0;
            r_burst_count <= '0;
            r_twin_used   <= '0;
            r_peak        <= '0;
            r_ov          <= 1'b0;
        end else begin
            r_rd_vld      <= n_rd_vld;
            r_found       <= n_found;
            r_shared_used <= n_shared_used;
            r_probe_used  <= n_probe_used;
            r_auth_used   <= n_auth_used;
            r_auth_fired  <= n_auth_fired;
            r_auth_ws     <= n_auth_ws;
            r_burst_start <= n_burst_start;
            r_burst_count <= n_burst_count;
            r_twin_used   <= n_twin_used;
            r_peak        <= n_peak;
            r_ov          <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind; r_mac <= n_mac; r_now <= n_now;
        r_idx <= n_idx; r_rd_idx <= n_rd_idx; r_pick <= n_pick; r_min_idx <= n_min_idx;
        r_min_start <= n_min_start; r_cnt <= n_cnt; r_start <= n_start;
        r_ev_kind <= n_ev_kind; r_ev_sev <= n_ev_sev; r_ev_msg <= n_ev_msg;
        r_o_kind <= n_o_kind; r_o_sev <= n_o_sev; r_o_mac <= n_o_mac;
        r_o_msg <= n_o_msg; r_o_max <= n_o_max;
    end

    assign o_out.valid         = r_ov;
    assign o_out.event_kind    = r_o_kind;
    assign o_out.severity      = r_o_sev;
    assign o_out.event_mac     = r_o_mac;
    assign o_out.event_msg_num = r_o_msg;
    assign o_out.max_severity  = r_o_max;

    `WIRD_ASSERT(a_out_peak, o_out.valid |-> o_out.max_severity >= o_out.severity)
    `WIRD_ASSERT(a_scan_bound, r_rd_vld |-> r_rd_idx < lim)
    `WIRD_ASSERT(a_auth_bound, r_auth_used <= AU_W'(AUTH_ENTRIES))
    `WIRD_ASSERT_ANY(a_peak_mono, i_rst_n && $past(i_rst_n) |-> r_peak >= $past(r_peak))
endmodule

### sim/wird_checker.sv
// event predictor and scoreboard for the wireless intrusion rate detector
`timescale 1ns / 1ps
module wird_checker
    import wird_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    wird_in_if          frames,
    wird_out_if         events,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    input  logic        pready,
    input  logic        i_done,
    output int          o_errors,
    output int          o_pending,
    output int          o_events
);
    typedef struct packed {
        logic [2:0]  kind;
        logic [1:0]  sev;
        logic [47:0] mac;
        logic [2:0]  msg;
        logic [1:0]  peak;
    } alert_t;

    alert_t      pending_alerts[$];

    logic [47:0] target_bssid;
    logic [15:0] deauth_thr, probe_thr, assoc_thr;
    logic [5:0]  flood_thr;
    logic [7:0]  harvest_thr;

    // table 0 is deauth and assoc, table 1 is probe
    logic [47:0] rate_mac[2][16];
    logic [15:0] rate_cnt[2][16];
    logic [31:0] rate_start[2][16];
    int          rate_used[2];
    logic [47:0] auth_mac[32];
    int          auth_used;
    bit          auth_fired;
    logic [31:0] auth_win_start;
    logic [31:0] burst_start;
    logic [15:0] burst_count;
    logic [47:0] rogue_mac[8];
    int          rogue_used;
    logic [1:0]  peak_sev;
    bit          done_seen;

    function automatic logic [15:0] bump_rate(int t, logic [47:0] mac, logic [31:0] now,
                                              logic [31:0] win);
        int pick;
        bit found;
        logic [31:0] age;
        pick = 0;
        found = 0;
        for (int i = 0; i < rate_used[t]; i++) begin
            if (!found && rate_mac[t][i] == mac) begin
                pick = i;
                found = 1;
            end
        end
        if (!found) begin
            if (rate_used[t] < 16) begin
                pick = rate_used[t];
                rate_used[t]++;
            end else begin
                for (int i = 1; i < 16; i++)
                    if (rate_start[t][i] < rate_start[t][pick]) pick = i;
            end
            rate_mac[t][pick] = mac;
            rate_cnt[t][pick] = 0;
            rate_start[t][pick] = now;
        end
        age = now - rate_start[t][pick];
        if (age > win) begin
            rate_cnt[t][pick] = 0;
            rate_start[t][pick] = now;
        end
        if (rate_cnt[t][pick] != COUNT_MAX) rate_cnt[t][pick]++;
        return rate_cnt[t][pick];
    endfunction

    task automatic raise_alert(logic [2:0] kind, logic [1:0] sev, logic [47:0] mac,
                               logic [2:0] msg);
        alert_t a;
        if (sev > peak_sev) peak_sev = sev;
        a.kind = kind;
        a.sev = sev;
        a.mac = mac;
        a.msg = msg;
        a.peak = peak_sev;
        pending_alerts.push_back(a);
    endtask

    task automatic predict_frame(logic [2:0] kind, logic [47:0] mac, logic [2:0] msg,
                                 logic [31:0] now);
        bit seen;
        logic [31:0] age;
        seen = 0;
        case (kind)
            K_ASSOC: begin
                if (bump_rate(0, mac, now, SHORT_WIN) == assoc_thr)
                    raise_alert(EV_ASSOC, SEV_WARN, mac, 3'd0);
            end
            K_PROBE: begin
                if (bump_rate(1, mac, now, SHORT_WIN) == probe_thr)
                    raise_alert(EV_PROBE, SEV_WARN, mac, 3'd0);
            end
            K_AUTH: begin
                age = now - auth_win_start;
                if (age > LONG_WIN) begin
                    auth_win_start = now;
                    auth_used = 0;
                    auth_fired = 0;
                end
                if (!auth_fired) begin
                    for (int i = 0; i < auth_used; i++)
                        if (auth_mac[i] == mac) seen = 1;
                    if (!seen && auth_used < 32) begin
                        auth_mac[auth_used] = mac;
                        auth_used++;
                    end
                    if (auth_used >= int'(flood_thr)) begin
                        auth_fired = 1;
                        raise_alert(EV_AUTH, SEV_WARN, mac, 3'd0);
                    end
                end
            end
            K_DEAUTH: begin
                if (bump_rate(0, mac, now, LONG_WIN) == deauth_thr)
                    raise_alert(EV_DEAUTH, SEV_CRIT, mac, 3'd0);
                age = now - burst_start;
                if (age > BURST_WIN) begin
                    burst_start = now;
                    burst_count = 0;
                end
                if (burst_count != COUNT_MAX) burst_count++;
            end
            K_TWIN: begin
                for (int i = 0; i < rogue_used; i++)
                    if (rogue_mac[i] == mac) seen = 1;
                if (!seen) begin
                    if (rogue_used < 8) begin
                        rogue_mac[rogue_used] = mac;
                        rogue_used++;
                    end
                    if (mac[47:24] == target_bssid[47:24])
                        raise_alert(EV_COAP, SEV_INFO, mac, 3'd0);
                    else
                        raise_alert(EV_TWIN, SEV_WARN, mac, 3'd0);
                end
            end
            K_BFLOOD: raise_alert(EV_BFLOOD, SEV_WARN, mac, 3'd0);
            K_EAPOL: begin
                age = now - burst_start;
                if (burst_count >= 16'(harvest_thr) && age < BURST_WIN) begin
                    raise_alert(EV_HARVEST, SEV_CRIT, mac, msg);
                    burst_count = 0;
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_field(string name, logic [47:0] want, logic [47:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            o_errors++;
        end
    endtask

    initial begin
        o_errors = 0;
        o_events = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        alert_t want;
        if (!i_rst_n) begin
            target_bssid = '0;
            deauth_thr = 16'd5;
            probe_thr = 16'd50;
            assoc_thr = 16'd5;
            flood_thr = 6'd32;
            harvest_thr = 8'd3;
            rate_used[0] = 0;
            rate_used[1] = 0;
            auth_used = 0;
            auth_fired = 0;
            auth_win_start = '0;
            burst_start = '0;
            burst_count = '0;
            rogue_used = 0;
            peak_sev = SEV_INFO;
            pending_alerts.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[5:3])
                    REG_TARGET: target_bssid = pwdata[47:0];
                    REG_DEAUTH: deauth_thr = pwdata[15:0];
                    REG_PROBE:  probe_thr = pwdata[15:0];
                    REG_ASSOC:  assoc_thr = pwdata[15:0];
                    REG_FLOOD:  flood_thr = pwdata[5:0];
                    REG_HSMIN:  harvest_thr = pwdata[7:0];
                    default: ;
                endcase
            end
            if (events.valid && events.ready) begin
                o_events++;
                if (pending_alerts.size() == 0) begin
                    $display("%0t: event with none expected, actual kind %0d mac %0h",
                             $time, events.event_kind, events.event_mac);
                    o_errors++;
                end else begin
                    want = pending_alerts.pop_front();
                    check_field("event_kind", 48'(want.kind), 48'(events.event_kind));
                    check_field("severity", 48'(want.sev), 48'(events.severity));
                    check_field("event_mac", want.mac, events.event_mac);
                    check_field("event_msg_num", 48'(want.msg), 48'(events.event_msg_num));
                    check_field("max_severity", 48'(want.peak), 48'(events.max_severity));
                end
            end
            if (frames.valid && frames.ready)
                predict_frame(frames.req_type, frames.src_mac, frames.eapol_msg,
                              frames.now_ms);
        end
        if (i_done && !done_seen) begin
            done_seen = 1;
            if (pending_alerts.size() != 0) begin
                $display("%0t: %0d events expected, actual none", $time,
                         pending_alerts.size());
                o_errors++;
            end
        end
        o_pending = pending_alerts.size();
    end
endmodule

### sim/tb_wireless_intrusion_rate_detector_top.sv
// stimulus and verdict for the wireless intrusion rate detector
`timescale 1ns / 1ps
module tb_wireless_intrusion_rate_detector_top;
    import wird_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    logic        done;
    int          errors, pending, seen_events;
    int          frame_count;
    logic [31:0] clock_ms;
    logic [47:0] cur_target;

    wird_in_if  frames();
    wird_out_if events();

    wireless_intrusion_rate_detector_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(frames), .o_out(events),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    wird_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .frames(frames), .events(events),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready), .i_done(done),
        .o_errors(errors), .o_pending(pending), .o_events(seen_events)
    );

    always #2 i_clk = ~i_clk;

    initial begin
        #10_000_000;
        $display("tb_wireless_intrusion_rate_detector_top: errors");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    initial begin
        int open_len, stall_len;
        events.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            open_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                   : $urandom_range(1, 8);
            stall_len = pick_gap();
            events.ready <= 1'b1;
            repeat (open_len) @(posedge i_clk);
            if (stall_len > 0) begin
                events.ready <= 1'b0;
                repeat (stall_len) @(posedge i_clk);
            end
        end
    end

    task automatic reg_write(logic [2:0] idx, logic [63:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_TARGET) cur_target = value[47:0];
    endtask

    task automatic wait_idle();
        frames.valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic load_thresholds(logic [47:0] target, logic [15:0] deauth,
                                   logic [15:0] probe, logic [15:0] assoc,
                                   logic [5:0] flood, logic [7:0] harvest);
        wait_idle();
        reg_write(REG_TARGET, 64'(target));
        reg_write(REG_DEAUTH, 64'(deauth));
        reg_write(REG_PROBE, 64'(probe));
        reg_write(REG_ASSOC, 64'(assoc));
        reg_write(REG_FLOOD, 64'(flood));
        reg_write(REG_HSMIN, 64'(harvest));
    endtask

    task automatic send_frame(logic [2:0] kind, logic [47:0] mac, logic [2:0] msg,
                              logic [31:0] now);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            frames.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        frames.valid <= 1'b1;
        frames.req_type <= kind;
        frames.src_mac <= mac;
        frames.eapol_msg <= msg;
        frames.now_ms <= now;
        @(posedge i_clk iff (frames.valid && frames.ready));
        frame_count++;
    endtask

    task automatic send_random_frame();
        int r;
        logic [2:0]  kind;
        logic [47:0] mac;
        r = $urandom_range(0, 99);
        if (r < 70) clock_ms += $urandom_range(0, 300);
        else if (r < 90) clock_ms += $urandom_range(0, 3000);
        else if (r < 98) clock_ms += $urandom_range(5000, 32000);
        else clock_ms = $urandom;
        r = $urandom_range(0, 99);
        if (r < 15) kind = K_ASSOC;
        else if (r < 30) kind = K_PROBE;
        else if (r < 50) kind = K_AUTH;
        else if (r < 70) kind = K_DEAUTH;
        else if (r < 78) kind = K_TWIN;
        else if (r < 83) kind = K_BFLOOD;
        else if (r < 97) kind = K_EAPOL;
        else kind = K_NONE;
        if ($urandom_range(0, 9) == 0)
            mac = {16'($urandom), 32'($urandom)};
        else if (kind == K_TWIN)
            mac = ($urandom_range(0, 1) == 0)
                ? {cur_target[47:24], 24'($urandom_range(0, 5))}
                : {24'h5A5A00 + 24'($urandom_range(0, 7)), 24'($urandom_range(0, 3))};
        else
            mac = {24'hA1B2C3, 24'($urandom_range(0, 23))};
        send_frame(kind, mac, 3'($urandom_range(0, 7)), clock_ms);
    endtask

    initial begin
        i_rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        done <= 1'b0;
        frames.valid <= 1'b0;
        frames.req_type <= K_ASSOC;
        frames.src_mac <= '0;
        frames.eapol_msg <= '0;
        frames.now_ms <= '0;
        frame_count = 0;
        clock_ms = 32'd0;
        cur_target = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, every kind, burst then harvest, co-ap vs twin
        load_thresholds(48'hA1B2C3_000000, 16'd3, 16'd2, 16'd2, 6'd3, 8'd2);
        send_frame(K_ASSOC, 48'h0, 3'd0, 32'd0);
        send_frame(K_ASSOC, 48'h0, 3'd0, 32'd10);
        send_frame(K_PROBE, 48'hFFFF_FFFF_FFFF, 3'd7, 32'hFFFF_FFFF);
        send_frame(K_PROBE, 48'hFFFF_FFFF_FFFF, 3'd0, 32'd100);
        send_frame(K_AUTH, 48'h1, 3'd0, 32'd200);
        send_frame(K_AUTH, 48'h2, 3'd0, 32'd210);
        send_frame(K_AUTH, 48'h2, 3'd0, 32'd220);
        send_frame(K_AUTH, 48'h3, 3'd0, 32'd230);
        send_frame(K_AUTH, 48'h4, 3'd0, 32'd240);
        send_frame(K_EAPOL, 48'h55, 3'd1, 32'd300);
        send_frame(K_DEAUTH, 48'hDEAD, 3'd0, 32'd400);
        send_frame(K_DEAUTH, 48'hDEAD, 3'd0, 32'd410);
        send_frame(K_EAPOL, 48'h55, 3'd4, 32'd420);
        send_frame(K_DEAUTH, 48'hDEAD, 3'd0, 32'd430);
        send_frame(K_TWIN, 48'hA1B2C3_777777, 3'd0, 32'd500);
        send_frame(K_TWIN, 48'hA1B2C3_777777, 3'd0, 32'd510);
        send_frame(K_TWIN, 48'h123456_777777, 3'd0, 32'd520);
        send_frame(K_BFLOOD, 48'hBEEF, 3'd2, 32'd600);
        send_frame(K_NONE, 48'hFFFF_FFFF_FFFF, 3'd7, 32'hFFFF_FFFF);
        send_frame(K_AUTH, 48'h9, 3'd0, 32'd40000);
        send_frame(K_EAPOL, 48'h55, 3'd3, 32'd70000);
        clock_ms = 32'd70000;

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: ;
                1: load_thresholds(48'hFFFF_FFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                   6'd63, 8'hFF);
                2: load_thresholds(48'h0, 16'd1, 16'd1, 16'd1, 6'd1, 8'd1);
                3: load_thresholds(48'hA1B2C3_000000, 16'd0, 16'd0, 16'd0, 6'd0, 8'd0);
                4: load_thresholds(48'hA1B2C3_123456, 16'd5, 16'd50, 16'd5, 6'd32, 8'd3);
                default: load_thresholds({16'($urandom), 32'($urandom)},
                                         16'($urandom_range(1, 8)),
                                         16'($urandom_range(1, 8)),
                                         16'($urandom_range(1, 8)),
                                         6'($urandom_range(1, 8)),
                                         8'($urandom_range(1, 8)));
            endcase
            if (phase == 5) clock_ms = 32'hFFFF_0000;
            for (int n = 0; n < 305; n++) begin
                if (phase == 2 && n == 150) begin
                    frames.valid <= 1'b0;
                    wait (pending == 0);
                    @(posedge i_clk);
                end
                send_random_frame();
            end
        end

        wait_idle();
        done <= 1'b1;
        repeat (2) @(posedge i_clk);
        $display("covered %0d frames over six threshold settings, %0d events compared",
                 frame_count, seen_events);
        if (errors == 0)
            $display("tb_wireless_intrusion_rate_detector_top: clean");
        else
            $display("tb_wireless_intrusion_rate_detector_top: errors");
        $finish;
    end
endmodule
